// File: rtl/pidpd_pkg.sv
// Shared widths, register indexes and clamp helpers for the PID position/delta controller.
package pidpd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF1_W   = 18;
    localparam int DIFF2_W   = 19;
    localparam int GAIN_W    = 16;
    localparam int P_PROD_W  = GAIN_W + DIFF1_W;
    localparam int I_PROD_W  = GAIN_W + ERR_W;
    localparam int D_PROD_W  = GAIN_W + DIFF2_W;
    localparam int ACC_W     = 48;
    localparam int LIM_W     = 31;
    localparam int FRAC_W    = 8;
    localparam int DRIVE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd5;

    localparam logic MODE_POSITION = 1'b0;
    localparam logic MODE_DELTA    = 1'b1;

    localparam logic signed [ERR_W-1:0] INT_WINDOW = 17'sd300;

    typedef logic signed [ACC_W-1:0] acc_t;

    function automatic acc_t limit_q8(input logic [LIM_W-1:0] lim);
        return acc_t'({{(ACC_W - LIM_W - FRAC_W){1'b0}}, lim, {FRAC_W{1'b0}}});
    endfunction

    function automatic acc_t clamp_sym(input acc_t v, input logic [LIM_W-1:0] lim);
        acc_t hi;
        acc_t lo;
        hi = limit_q8(lim);
        lo = -hi;
        if (v > hi)
        begin
            return hi;
        end
        else if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

endpackage

// File: rtl/pid_position_delta_controller.sv
// Top level of the PID controller with positional and incremental modes.
// An accepted input passes the error, product and drive registers; the integral and
// accumulator update in the last stage. One transaction per cycle while m_tready is high.
// The error stage, the multiplier stage and the accumulate/clamp stage each hold one item.
// Reset (rst_n low, asynchronous) clears the error history, integral, accumulator,
// all configuration registers and the pipeline valid flags.
module pid_position_delta_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // measured [15:0], setpoint [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive [31:0]
    input  logic                                cfg_wr_en,
    input  logic [pidpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                                   loop_mode_reg;
    logic [pidpd_pkg::LIM_W-1:0]            output_limit_reg;
    logic [pidpd_pkg::LIM_W-1:0]            integral_limit_reg;
    logic signed [pidpd_pkg::GAIN_W-1:0]    gain_p_reg;
    logic signed [pidpd_pkg::GAIN_W-1:0]    gain_i_reg;
    logic signed [pidpd_pkg::GAIN_W-1:0]    gain_d_reg;

    logic signed [pidpd_pkg::ERR_W-1:0]     err_prev_reg;
    logic signed [pidpd_pkg::ERR_W-1:0]     err_prev2_reg;
    pidpd_pkg::acc_t                        integral_sum_reg;
    pidpd_pkg::acc_t                        output_accum_reg;

    logic                                   s1_valid_reg;
    logic                                   s2_valid_reg;
    logic                                   out_valid_reg;
    logic                                   ready2;
    logic                                   ready3;
    logic                                   in_accept;
    logic                                   commit;

    logic signed [pidpd_pkg::SAMPLE_W-1:0]  measured;
    logic signed [pidpd_pkg::SAMPLE_W-1:0]  setpoint;
    logic signed [pidpd_pkg::ERR_W-1:0]     err_next;
    logic signed [pidpd_pkg::DIFF1_W-1:0]   diff1_next;
    logic signed [pidpd_pkg::DIFF2_W-1:0]   diff2_next;
    logic                                   win_next;

    logic signed [pidpd_pkg::ERR_W-1:0]     err_reg;
    logic signed [pidpd_pkg::DIFF1_W-1:0]   diff1_reg;
    logic signed [pidpd_pkg::DIFF2_W-1:0]   diff2_reg;
    logic                                   win_reg;

    logic signed [pidpd_pkg::DIFF1_W-1:0]   p_oper;
    logic signed [pidpd_pkg::DIFF2_W-1:0]   d_oper;
    logic signed [pidpd_pkg::P_PROD_W-1:0]  p_prod_next;
    logic signed [pidpd_pkg::I_PROD_W-1:0]  i_prod_next;
    logic signed [pidpd_pkg::D_PROD_W-1:0]  d_prod_next;

    logic signed [pidpd_pkg::P_PROD_W-1:0]  p_prod_reg;
    logic signed [pidpd_pkg::I_PROD_W-1:0]  i_prod_reg;
    logic signed [pidpd_pkg::D_PROD_W-1:0]  d_prod_reg;
    logic                                   win2_reg;

    pidpd_pkg::acc_t                        p_ext;
    pidpd_pkg::acc_t                        i_ext;
    pidpd_pkg::acc_t                        d_ext;
    pidpd_pkg::acc_t                        integral_sum_next;
    pidpd_pkg::acc_t                        output_accum_next;
    logic [pidpd_pkg::DRIVE_W-1:0]          drive_next;
    logic [pidpd_pkg::DRIVE_W-1:0]          drive_reg;

    assign ready3    = !out_valid_reg || m_tready;
    assign ready2    = !s2_valid_reg || ready3;
    assign s_tready  = !s1_valid_reg || ready2;
    assign in_accept = s_tvalid && s_tready;
    assign commit    = s2_valid_reg && ready3;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = drive_reg;

    // Error stage: new error, its first and second differences, and the integral window flag.
    always_comb
    begin
        measured   = s_tdata[pidpd_pkg::SAMPLE_W-1:0];
        setpoint   = s_tdata[2*pidpd_pkg::SAMPLE_W-1:pidpd_pkg::SAMPLE_W];
        err_next   = pidpd_pkg::ERR_W'(setpoint) - pidpd_pkg::ERR_W'(measured);
        diff1_next = pidpd_pkg::DIFF1_W'(err_next) - pidpd_pkg::DIFF1_W'(err_prev_reg);
        diff2_next = pidpd_pkg::DIFF2_W'(err_next)
                   - (pidpd_pkg::DIFF2_W'(err_prev_reg) <<< 1)
                   + pidpd_pkg::DIFF2_W'(err_prev2_reg);
        win_next   = (err_next < pidpd_pkg::INT_WINDOW) && (err_next > -pidpd_pkg::INT_WINDOW);
    end

    // Multiplier stage: the operands of P and D depend on the mode.
    always_comb
    begin
        if (loop_mode_reg == pidpd_pkg::MODE_DELTA)
        begin
            p_oper = diff1_reg;
            d_oper = diff2_reg;
        end
        else
        begin
            p_oper = pidpd_pkg::DIFF1_W'(err_reg);
            d_oper = pidpd_pkg::DIFF2_W'(diff1_reg);
        end
        p_prod_next = pidpd_pkg::P_PROD_W'(gain_p_reg) * pidpd_pkg::P_PROD_W'(p_oper);
        i_prod_next = pidpd_pkg::I_PROD_W'(gain_i_reg) * pidpd_pkg::I_PROD_W'(err_reg);
        d_prod_next = pidpd_pkg::D_PROD_W'(gain_d_reg) * pidpd_pkg::D_PROD_W'(d_oper);
    end

    // Accumulate and clamp stage.
    always_comb
    begin
        p_ext = pidpd_pkg::acc_t'(p_prod_reg);
        i_ext = pidpd_pkg::acc_t'(i_prod_reg);
        d_ext = pidpd_pkg::acc_t'(d_prod_reg);
        if (loop_mode_reg == pidpd_pkg::MODE_DELTA)
        begin
            integral_sum_next = i_ext;
            output_accum_next = pidpd_pkg::clamp_sym(output_accum_reg + p_ext + i_ext + d_ext,
                                                     output_limit_reg);
        end
        else
        begin
            integral_sum_next = pidpd_pkg::clamp_sym(
                integral_sum_reg + (win2_reg ? i_ext : pidpd_pkg::acc_t'(0)),
                integral_limit_reg);
            output_accum_next = pidpd_pkg::clamp_sym(p_ext + integral_sum_next + d_ext,
                                                     output_limit_reg);
        end
        drive_next = output_accum_next[pidpd_pkg::FRAC_W +: pidpd_pkg::DRIVE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg      <= pidpd_pkg::MODE_POSITION;
            output_limit_reg   <= '0;
            integral_limit_reg <= '0;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pidpd_pkg::REG_LOOP_MODE:      loop_mode_reg      <= cfg_data[0];
                pidpd_pkg::REG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data;
                pidpd_pkg::REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data;
                pidpd_pkg::REG_GAIN_P:         gain_p_reg <= cfg_data[pidpd_pkg::GAIN_W-1:0];
                pidpd_pkg::REG_GAIN_I:         gain_i_reg <= cfg_data[pidpd_pkg::GAIN_W-1:0];
                pidpd_pkg::REG_GAIN_D:         gain_d_reg <= cfg_data[pidpd_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            err_prev_reg     <= '0;
            err_prev2_reg    <= '0;
            integral_sum_reg <= '0;
            output_accum_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (in_accept)
            begin
                err_prev2_reg <= err_prev_reg;
                err_prev_reg  <= err_next;
            end
            if (commit)
            begin
                integral_sum_reg <= integral_sum_next;
                output_accum_reg <= output_accum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            err_reg   <= err_next;
            diff1_reg <= diff1_next;
            diff2_reg <= diff2_next;
            win_reg   <= win_next;
        end
        if (s1_valid_reg && ready2)
        begin
            p_prod_reg <= p_prod_next;
            i_prod_reg <= i_prod_next;
            d_prod_reg <= d_prod_next;
            win2_reg   <= win_reg;
        end
        if (commit)
        begin
            drive_reg <= drive_next;
        end
    end

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid)
        else $error("A committed item did not reach the output register.");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && !m_tready))
        else $error("Input stalled while the pipeline had room.");

    a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && loop_mode_reg == pidpd_pkg::MODE_POSITION) |=>
        ((integral_sum_reg <= pidpd_pkg::limit_q8($past(integral_limit_reg))) &&
         (integral_sum_reg >= -pidpd_pkg::limit_q8($past(integral_limit_reg)))))
        else $error("Integral left its clamp range in position mode.");

endmodule

// File: tb/pid_position_delta_controller_test.sv
// Self-checking stream testbench for the positional/incremental PID controller.
module pid_position_delta_controller_test;

    localparam int     ITEM_TOTAL   = 1350;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 10;
    localparam longint WINDOW       = 300;
    localparam longint TIMEOUT      = 64'd5_000_000;

    localparam logic [pidpd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [pidpd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [pidpd_pkg::LIM_W-1:0]     LIMIT_MAX    = {pidpd_pkg::LIM_W{1'b1}};
    localparam logic [pidpd_pkg::GAIN_W-1:0]    GAIN_MAX     = 16'h7FFF;
    localparam logic [pidpd_pkg::GAIN_W-1:0]    GAIN_MIN     = 16'h8000;
    localparam logic [pidpd_pkg::SAMPLE_W-1:0]  SAMPLE_MAX   = 16'h7FFF;
    localparam logic [pidpd_pkg::SAMPLE_W-1:0]  SAMPLE_MIN   = 16'h8000;

    typedef struct packed {
        logic                         mode;
        logic [pidpd_pkg::LIM_W-1:0]  out_lim;
        logic [pidpd_pkg::LIM_W-1:0]  int_lim;
        logic [pidpd_pkg::GAIN_W-1:0] kp;
        logic [pidpd_pkg::GAIN_W-1:0] ki;
        logic [pidpd_pkg::GAIN_W-1:0] kd;
    } setting_t;

    typedef struct packed {
        int                             set_id;
        logic [pidpd_pkg::SAMPLE_W-1:0] meas;
        logic [pidpd_pkg::SAMPLE_W-1:0] setp;
        logic                           typed;
        logic [pidpd_pkg::DRIVE_W-1:0]  drive;
    } sample_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [31:0]                      s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [31:0]                      m_tdata;
    logic                             cfg_wr_en;
    logic [pidpd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pidpd_pkg::CFG_DATA_W-1:0] cfg_data;

    logic   model_mode;
    longint model_out_lim;
    longint model_int_lim;
    longint model_kp;
    longint model_ki;
    longint model_kd;
    longint err_last;
    longint err_before;
    longint integral_q8;
    longint accum_q8;

    logic [pidpd_pkg::DRIVE_W-1:0] drive_expected[$];
    logic [pidpd_pkg::DRIVE_W-1:0] drive_due;
    sample_row_t                   sample_table[$];

    int mismatches      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int delta_items     = 0;
    int settings_used   = 0;
    bit calm            = 1'b0;
    bit hold_request    = 1'b0;

    pid_position_delta_controller i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("Timed out with %0d drive values outstanding", drive_expected.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("Mismatch at %0t: %s", $time, what);
    endtask

    function automatic longint clamp_q8(input longint v, input longint lim_q8);
        if (v > lim_q8)
        begin
            return lim_q8;
        end
        if (v < -lim_q8)
        begin
            return -lim_q8;
        end
        return v;
    endfunction

    task automatic compute_drive(input logic [pidpd_pkg::SAMPLE_W-1:0] meas_bits,
                                 input logic [pidpd_pkg::SAMPLE_W-1:0] setp_bits,
                                 output logic [pidpd_pkg::DRIVE_W-1:0] drive);
        longint e0;
        longint e1;
        longint e2;
        longint p;
        longint d;
        e2 = err_before;
        e1 = err_last;
        e0 = longint'($signed(setp_bits)) - longint'($signed(meas_bits));
        err_before = e1;
        err_last = e0;
        if (model_mode == pidpd_pkg::MODE_POSITION)
        begin
            p = model_kp * e0;
            d = model_kd * (e0 - e1);
            if (e0 < WINDOW && e0 > -WINDOW)
            begin
                integral_q8 = integral_q8 + model_ki * e0;
            end
            integral_q8 = clamp_q8(integral_q8, model_int_lim * 256);
            accum_q8 = clamp_q8(p + integral_q8 + d, model_out_lim * 256);
        end
        else
        begin
            p = model_kp * (e0 - e1);
            d = model_kd * (e0 - 2 * e1 + e2);
            integral_q8 = model_ki * e0;
            accum_q8 = clamp_q8(accum_q8 + p + integral_q8 + d, model_out_lim * 256);
        end
        drive = pidpd_pkg::DRIVE_W'(accum_q8 >>> pidpd_pkg::FRAC_W);
    endtask

    task automatic write_reg(input logic [pidpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pidpd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            pidpd_pkg::REG_LOOP_MODE:
                model_mode = data[0];
            pidpd_pkg::REG_OUTPUT_LIMIT:
                model_out_lim = longint'(data[pidpd_pkg::LIM_W-1:0]);
            pidpd_pkg::REG_INTEGRAL_LIMIT:
                model_int_lim = longint'(data[pidpd_pkg::LIM_W-1:0]);
            pidpd_pkg::REG_GAIN_P:
                model_kp = longint'($signed(data[pidpd_pkg::GAIN_W-1:0]));
            pidpd_pkg::REG_GAIN_I:
                model_ki = longint'($signed(data[pidpd_pkg::GAIN_W-1:0]));
            pidpd_pkg::REG_GAIN_D:
                model_kd = longint'($signed(data[pidpd_pkg::GAIN_W-1:0]));
            default:            ;
        endcase
    endtask

    task automatic apply_setting(input setting_t s, input bit junk);
        logic [pidpd_pkg::CFG_DATA_W-1:0] hi;
        hi = junk ? pidpd_pkg::CFG_DATA_W'($urandom) : '0;
        write_reg(pidpd_pkg::REG_LOOP_MODE, {hi[pidpd_pkg::CFG_DATA_W-1:1], s.mode});
        write_reg(pidpd_pkg::REG_OUTPUT_LIMIT, s.out_lim);
        write_reg(pidpd_pkg::REG_INTEGRAL_LIMIT, s.int_lim);
        write_reg(pidpd_pkg::REG_GAIN_P,
                  {hi[pidpd_pkg::CFG_DATA_W-1:pidpd_pkg::GAIN_W], s.kp});
        write_reg(pidpd_pkg::REG_GAIN_I,
                  {hi[pidpd_pkg::CFG_DATA_W-1:pidpd_pkg::GAIN_W], s.ki});
        write_reg(pidpd_pkg::REG_GAIN_D,
                  {hi[pidpd_pkg::CFG_DATA_W-1:pidpd_pkg::GAIN_W], s.kd});
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  pidpd_pkg::CFG_DATA_W'($urandom));
        settings_used++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (drive_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 99) < 55)
        begin
            return 0;
        end
        return stall_length();
    endfunction

    function automatic logic [pidpd_pkg::LIM_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return LIMIT_MAX;
        end
        if (r < 4)
        begin
            return pidpd_pkg::LIM_W'($urandom);
        end
        return pidpd_pkg::LIM_W'($urandom_range(1, 20000));
    endfunction

    function automatic logic [pidpd_pkg::GAIN_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
        begin
            return pidpd_pkg::GAIN_W'($urandom);
        end
        if (r == 1)
        begin
            return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
        end
        return pidpd_pkg::GAIN_W'($urandom_range(0, 1024)) - 16'd512;
    endfunction

    task automatic send_sample(input logic [pidpd_pkg::SAMPLE_W-1:0] meas,
                               input logic [pidpd_pkg::SAMPLE_W-1:0] setp,
                               input logic typed,
                               input logic [pidpd_pkg::DRIVE_W-1:0] typed_drive);
        logic [pidpd_pkg::DRIVE_W-1:0] predicted;
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {setp, meas};
        do
            @(posedge clk);
        while (!s_tready);
        compute_drive(meas, setp, predicted);
        drive_expected.push_back(typed ? typed_drive : predicted);
        items_sent++;
        if (model_mode == pidpd_pkg::MODE_DELTA)
        begin
            delta_items++;
        end
    endtask

    task automatic add_row(input int id, input logic [pidpd_pkg::SAMPLE_W-1:0] meas,
                           input logic [pidpd_pkg::SAMPLE_W-1:0] setp, input logic typed,
                           input logic [pidpd_pkg::DRIVE_W-1:0] drive);
        sample_row_t row;
        row.set_id = id;
        row.meas = meas;
        row.setp = setp;
        row.typed = typed;
        row.drive = drive;
        sample_table.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drive_expected.size() == 0)
            begin
                report_mismatch("output transaction with no drive value expected");
            end
            else
            begin
                drive_due = drive_expected.pop_front();
                results_checked++;
                if (m_tdata !== drive_due)
                begin
                    report_mismatch($sformatf("drive got %0d expected %0d",
                                              $signed(m_tdata), $signed(drive_due)));
                end
            end
        end
    end

    initial
    begin
        bit hold_served;
        hold_served = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready = 1'b0;
                repeat (stall_length()) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    initial
    begin
        setting_t    dir_set[6];
        setting_t    rs;
        sample_row_t row;
        int          cur;
        int          phase;
        int          len;
        int          kind;
        int          off;
        logic [pidpd_pkg::SAMPLE_W-1:0] meas;
        logic [pidpd_pkg::SAMPLE_W-1:0] setp;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        model_mode = pidpd_pkg::MODE_POSITION;
        model_out_lim = 0;
        model_int_lim = 0;
        model_kp = 0;
        model_ki = 0;
        model_kd = 0;
        err_last = 0;
        err_before = 0;
        integral_q8 = 0;
        accum_q8 = 0;

        dir_set[0] = '{pidpd_pkg::MODE_POSITION, '0, '0, '0, '0, '0};
        dir_set[1] = '{pidpd_pkg::MODE_POSITION, LIMIT_MAX, LIMIT_MAX,
                       GAIN_MAX, GAIN_MIN, GAIN_MAX};
        dir_set[2] = '{pidpd_pkg::MODE_DELTA, LIMIT_MAX, LIMIT_MAX,
                       GAIN_MIN, GAIN_MAX, GAIN_MIN};
        dir_set[3] = '{pidpd_pkg::MODE_POSITION, '0, '0, 16'h0100, 16'h0100, 16'h0100};
        dir_set[4] = '{pidpd_pkg::MODE_DELTA, 31'd1000, 31'd50,
                       16'h0100, 16'h0080, 16'hFFC0};
        dir_set[5] = '{pidpd_pkg::MODE_POSITION, LIMIT_MAX, 31'd20,
                       16'h0100, 16'h0080, 16'hFFC0};

        // Reset configuration: every gain and limit is zero.
        add_row(0, 16'd0, 16'd0, 1'b1, 32'd0);
        add_row(0, SAMPLE_MIN, SAMPLE_MAX, 1'b1, 32'd0);
        add_row(0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 32'd0);
        // Full-scale gains and limits, integral window edges on both sides.
        add_row(1, 16'd0, 16'd0, 1'b0, '0);
        add_row(1, SAMPLE_MIN, SAMPLE_MAX, 1'b0, '0);
        add_row(1, SAMPLE_MAX, SAMPLE_MIN, 1'b0, '0);
        add_row(1, 16'd0, 16'd299, 1'b0, '0);
        add_row(1, 16'd0, 16'd300, 1'b0, '0);
        add_row(1, 16'd300, 16'd0, 1'b0, '0);
        add_row(1, 16'd0, -16'sd299, 1'b0, '0);
        add_row(1, 16'd5, 16'd5, 1'b0, '0);
        // Switch to incremental mode; the accumulator carries over.
        add_row(2, 16'd0, 16'd0, 1'b0, '0);
        add_row(2, SAMPLE_MIN, SAMPLE_MAX, 1'b0, '0);
        add_row(2, SAMPLE_MAX, SAMPLE_MIN, 1'b0, '0);
        add_row(2, 16'd100, -16'sd100, 1'b0, '0);
        add_row(2, 16'd0, 16'd0, 1'b0, '0);
        // Zero limits clamp the drive to zero.
        add_row(3, 16'd0, 16'd1000, 1'b1, 32'd0);
        add_row(3, 16'd1000, 16'd0, 1'b1, 32'd0);
        add_row(3, 16'd0, 16'd100, 1'b1, 32'd0);
        // Incremental mode overwrites the integral, positional mode then resumes from it.
        add_row(4, 16'd0, 16'd100, 1'b0, '0);
        add_row(4, 16'd0, 16'd200, 1'b0, '0);
        add_row(4, 16'd0, 16'd250, 1'b0, '0);
        add_row(5, 16'd0, 16'd1000, 1'b0, '0);
        add_row(5, 16'd0, 16'd10, 1'b0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cur = 0;
        foreach (sample_table[k])
        begin
            row = sample_table[k];
            if (row.set_id != cur)
            begin
                wait_for_results();
                apply_setting(dir_set[row.set_id], 1'b0);
                cur = row.set_id;
            end
            send_sample(row.meas, row.setp, row.typed, row.drive);
        end

        phase = 0;
        while (items_sent < ITEM_TOTAL)
        begin
            wait_for_results();
            rs.mode = $urandom_range(0, 1) ? pidpd_pkg::MODE_DELTA : pidpd_pkg::MODE_POSITION;
            rs.out_lim = pick_limit();
            rs.int_lim = pick_limit();
            rs.kp = pick_gain();
            rs.ki = pick_gain();
            rs.kd = pick_gain();
            apply_setting(rs, 1'b1);
            calm = ($urandom_range(0, 4) == 0);
            if (phase == 3)
            begin
                calm = 1'b1;
                hold_request = 1'b1;
            end
            len = $urandom_range(20, 80);
            repeat (len)
            begin
                kind = $urandom_range(0, 9);
                meas = pidpd_pkg::SAMPLE_W'($urandom);
                if (kind < 2)
                begin
                    setp = pidpd_pkg::SAMPLE_W'($urandom);
                end
                else if (kind == 9)
                begin
                    meas = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                    setp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                end
                else
                begin
                    off = $urandom_range(0, 800) - 400;
                    setp = meas + off[pidpd_pkg::SAMPLE_W-1:0];
                end
                send_sample(meas, setp, 1'b0, '0);
            end
            phase++;
        end

        calm = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (drive_expected.size() != 0)
        begin
            report_mismatch("drive values still expected at the end");
        end

        $display("Sent %0d samples (%0d in incremental mode), checked %0d drive values",
                 items_sent, delta_items, results_checked);
        $display("Applied %0d register settings, zero and full-scale limits and gains among them",
                 settings_used);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/pidpd_pkg.sv
rtl/pid_position_delta_controller.sv
tb/pid_position_delta_controller_test.sv
